// File: design/spkg_pkg.sv
// Shared types, constants and helper functions of the shuffle pool keystream generator.
`default_nettype none
package spkg_pkg;
	localparam int unsigned POOL_DEPTH = 128;
	localparam int unsigned POOL_AW    = $clog2(POOL_DEPTH);
	localparam logic [31:0] GOLDEN_WORD = 32'h9e3779b9;

	typedef enum logic [1:0] {
		REQ_RESTART = 2'd0,
		REQ_KEY     = 2'd1,
		REQ_COMMIT  = 2'd2,
		REQ_DRAW    = 2'd3
	} req_t;

	typedef struct packed {
		req_t       req;
		logic [6:0] byte_index;
		logic [7:0] key_byte;
	} cmd_t;

	// rotation amounts: which = 0 for the b rotate, 1 for c, 2 for d
	function automatic logic [4:0] rot_amt(input logic [1:0] sel, input logic [1:0] which);
		logic [4:0] r;
		r = 5'd0;
		case (sel)
			2'd0: r = (which == 2'd0) ? 5'd14 : (which == 2'd1) ? 5'd9  : 5'd16;
			2'd1: r = (which == 2'd0) ? 5'd17 : (which == 2'd1) ? 5'd8  : 5'd14;
			2'd2: r = (which == 2'd0) ? 5'd17 : (which == 2'd1) ? 5'd19 : 5'd30;
			2'd3: r = (which == 2'd0) ? 5'd15 : (which == 2'd1) ? 5'd9  : 5'd24;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] k);
		logic [63:0] w;
		w = {x, x} << k;
		return w[63:32];
	endfunction
endpackage
`default_nettype wire

// File: design/spkg_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module spkg_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: design/spkg_front.sv
// Input side: accepts request beats and holds them in a two-entry command queue.
`default_nettype none
module spkg_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [1:0]      req_type,
	input  wire logic [6:0]      key_byte_index,
	input  wire logic [7:0]      key_byte,
	output logic                 cmd_valid,
	output spkg_pkg::cmd_t       cmd,
	input  wire logic            cmd_pop
);
	import spkg_pkg::*;

	cmd_t       entry_q [2];
	logic [1:0] count_q;
	logic       push;
	cmd_t       in_cmd;
	logic [1:0] count_after_pop;

	assign in_ready  = (count_q != 2'd2);
	assign push      = in_valid && in_ready;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = entry_q[0];
	assign count_after_pop = count_q - {1'b0, cmd_pop};

	always_comb begin
		in_cmd.req        = req_t'(req_type);
		in_cmd.byte_index = key_byte_index;
		in_cmd.key_byte   = key_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_after_pop + {1'b0, push};
		end
	end

	// shift on pop, then place the new beat behind what remains
	always_ff @(posedge clk) begin
		if (push && !count_after_pop[0]) begin
			entry_q[0] <= in_cmd;
		end else if (cmd_pop) begin
			entry_q[0] <= entry_q[1];
		end
		if (push && count_after_pop[0]) begin
			entry_q[1] <= in_cmd;
		end
	end
endmodule
`default_nettype wire

// File: design/spkg_engine.sv
// Back end: pool mixing sequencer, key writes, draws, warm-up and the output register.
`default_nettype none
module spkg_engine (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cmd_valid,
	input  wire spkg_pkg::cmd_t  cmd,
	output logic                 cmd_pop,
	input  wire logic [15:0]     warmup_rounds,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [31:0]          random_value
);
	import spkg_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_KWR  = 7'b0000010,
		ST_DRD  = 7'b0000100,
		ST_RA   = 7'b0001000,
		ST_RE   = 7'b0010000,
		ST_RD   = 7'b0100000,
		ST_WARM = 7'b1000000
	} state_t;

	state_t               state_q;
	logic [31:0]          b_q, c_q, d_q, e_q, wval_q;
	logic [1:0]           rsel_q;
	logic [POOL_AW-1:0]   didx_q, i_q, slot_q, kword_q;
	logic [1:0]           kbsel_q;
	logic [7:0]           kbyte_q;
	logic [15:0]          warm_q;
	logic                 to_warm_q, fwd_q, rvld_q, bvld_q;
	logic [POOL_DEPTH-1:0] pool_vld_q, buf_vld_q;
	logic                 out_valid_q;
	logic [31:0]          out_q;

	logic                 pool_we, buf_we;
	logic [POOL_AW-1:0]   pool_waddr, pool_raddr;
	logic [31:0]          pool_wdata, pool_rdata, buf_rdata;
	logic [31:0]          pool_p, e, wv, nb, nd, fwd_word, kmask, kval, kmerged;
	logic [POOL_AW-1:0]   cmd_word;

	assign out_valid    = out_valid_q;
	assign random_value = out_q;

	assign cmd_word = POOL_AW'(cmd.byte_index[6:2]);
	assign cmd_pop  = (state_q == ST_IDLE) && cmd_valid
		&& ((cmd.req != REQ_DRAW) || !out_valid_q);

	assign pool_p   = rvld_q ? pool_rdata : GOLDEN_WORD;
	assign e        = pool_p - rotl32(b_q, rot_amt(rsel_q, 2'd0));
	assign wv       = b_q ^ rotl32(c_q, rot_amt(rsel_q, 2'd1));
	assign nb       = c_q + rotl32(d_q, rot_amt(rsel_q, 2'd2));
	assign fwd_word = fwd_q ? wval_q : pool_p;
	assign nd       = e_q + fwd_word;
	assign kmask    = ~(32'hFF << {kbsel_q, 3'b000});
	assign kval     = {24'd0, kbyte_q} << {kbsel_q, 3'b000};
	assign kmerged  = (pool_p & kmask) | kval;

	always_comb begin
		case (state_q)
			ST_IDLE: pool_raddr = cmd_word;
			ST_RE:   pool_raddr = nb[POOL_AW-1:0];
			default: pool_raddr = d_q[POOL_AW-1:0];
		endcase
		pool_we    = (state_q == ST_KWR) || (state_q == ST_RE);
		pool_waddr = (state_q == ST_KWR) ? kword_q : slot_q;
		pool_wdata = (state_q == ST_KWR) ? kmerged : wv;
		buf_we     = (state_q == ST_RD);
	end

	spkg_ram #(.WIDTH(32), .DEPTH(POOL_DEPTH)) u_pool (
		.clk   (clk),
		.we    (pool_we),
		.waddr (pool_waddr),
		.wdata (pool_wdata),
		.raddr (pool_raddr),
		.rdata (pool_rdata)
	);

	spkg_ram #(.WIDTH(32), .DEPTH(POOL_DEPTH)) u_buf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (i_q),
		.wdata (nd),
		.raddr (didx_q),
		.rdata (buf_rdata)
	);

	// payload side registers
	always_ff @(posedge clk) begin
		rvld_q <= pool_vld_q[pool_raddr];
		bvld_q <= buf_vld_q[didx_q];
		if (state_q == ST_IDLE) begin
			kword_q <= cmd_word;
			kbsel_q <= cmd.byte_index[1:0];
			kbyte_q <= cmd.key_byte;
		end
		if (state_q == ST_RA) begin
			slot_q <= d_q[POOL_AW-1:0];
		end
		if (state_q == ST_RE) begin
			e_q    <= e;
			wval_q <= wv;
			fwd_q  <= (nb[POOL_AW-1:0] == slot_q);
		end
		if (state_q == ST_DRD) begin
			out_q <= bvld_q ? buf_rdata : 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			b_q         <= GOLDEN_WORD;
			c_q         <= GOLDEN_WORD;
			d_q         <= GOLDEN_WORD;
			rsel_q      <= 2'd0;
			didx_q      <= '0;
			i_q         <= '0;
			warm_q      <= 16'd0;
			to_warm_q   <= 1'b0;
			pool_vld_q  <= '0;
			buf_vld_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						case (cmd.req)
							REQ_RESTART: begin
								b_q        <= GOLDEN_WORD;
								c_q        <= GOLDEN_WORD;
								d_q        <= GOLDEN_WORD;
								rsel_q     <= 2'd0;
								didx_q     <= '0;
								pool_vld_q <= '0;
								buf_vld_q  <= '0;
							end
							REQ_KEY:    state_q <= ST_KWR;
							REQ_COMMIT: begin
								warm_q    <= warmup_rounds;
								to_warm_q <= 1'b1;
								i_q       <= '0;
								state_q   <= ST_RA;
							end
							REQ_DRAW:   state_q <= ST_DRD;
							default:    state_q <= ST_IDLE;
						endcase
					end
				end
				ST_KWR: begin
					pool_vld_q[kword_q] <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_DRD: begin
					out_valid_q <= 1'b1;
					didx_q <= didx_q + 1'b1;
					if (didx_q == POOL_AW'(POOL_DEPTH - 1)) begin
						to_warm_q <= 1'b0;
						i_q       <= '0;
						state_q   <= ST_RA;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_RA: state_q <= ST_RE;
				ST_RE: begin
					pool_vld_q[slot_q] <= 1'b1;
					b_q     <= nb;
					c_q     <= d_q + e;
					state_q <= ST_RD;
				end
				ST_RD: begin
					d_q <= nd;
					buf_vld_q[i_q] <= 1'b1;
					i_q <= i_q + 1'b1;
					if (i_q == POOL_AW'(POOL_DEPTH - 1)) begin
						rsel_q  <= c_q[1:0];
						state_q <= to_warm_q ? ST_WARM : ST_IDLE;
					end else begin
						state_q <= ST_RA;
					end
				end
				ST_WARM: begin
					// discard one draw per cycle, refilling at the end of the buffer
					if (warm_q == 16'd0) begin
						state_q <= ST_IDLE;
					end else begin
						warm_q <= warm_q - 16'd1;
						didx_q <= didx_q + 1'b1;
						if (didx_q == POOL_AW'(POOL_DEPTH - 1)) begin
							i_q     <= '0;
							state_q <= ST_RA;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: design/shuffle_pool_keystream_generator.sv
// Top level of the shuffle pool keystream generator.
`default_nettype none
// A request beat enters a two-entry queue and is carried out by a sequencer over a 128-word
// pool RAM and a 128-word output buffer RAM, one item at a time. Restart is carried out in
// the idle state itself, a key byte write reads and then merges and writes back its pool
// word, and a draw moves a word from the buffer RAM into the output register. A refill,
// after every 128th draw and on a key commit, runs 128 rounds, each a pool read, a pool
// write with the second read, and a buffer write. A commit then discards warmup_rounds
// draws, with a refill each time they reach the end of the buffer.
// Reset and restart clear per-entry valid bits at once, so no clearing pass is needed.
module shuffle_pool_keystream_generator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  req_type,
	input  wire logic [6:0]  key_byte_index,
	input  wire logic [7:0]  key_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      random_value
);
	import spkg_pkg::*;

	logic [15:0] warmup_q;
	logic        cmd_valid, cmd_pop;
	cmd_t        cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warmup_q <= 16'd0;
		end else if (cfg_wr_en) begin
			warmup_q <= cfg_wr_data;
		end
	end

	spkg_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.req_type       (req_type),
		.key_byte_index (key_byte_index),
		.key_byte       (key_byte),
		.cmd_valid      (cmd_valid),
		.cmd            (cmd),
		.cmd_pop        (cmd_pop)
	);

	spkg_engine u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd),
		.cmd_pop       (cmd_pop),
		.warmup_rounds (warmup_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.random_value  (random_value)
	);
endmodule
`default_nettype wire

// File: bench/tb_shuffle_pool_keystream_generator.sv
// Self-checking testbench for the shuffle pool keystream generator.
`default_nettype none
module tb_shuffle_pool_keystream_generator;
	import spkg_pkg::*;

	class keystream_scoreboard;
		logic [31:0] pool_words [POOL_DEPTH];
		logic [31:0] out_words [POOL_DEPTH];
		logic [31:0] mb, mc, md;
		logic [1:0]  rot_sel;
		logic [6:0]  draw_ptr;
		logic [15:0] warmup;
		logic [31:0] expected_words [$];
		int          errors;
		int          draws_seen;
		int          refills;

		function void restart();
			for (int i = 0; i < POOL_DEPTH; i++) begin
				pool_words[i] = GOLDEN_WORD;
				out_words[i] = 32'd0;
			end
			mb = GOLDEN_WORD;
			mc = GOLDEN_WORD;
			md = GOLDEN_WORD;
			rot_sel = 2'd0;
			draw_ptr = 7'd0;
		endfunction

		function logic [31:0] rol(logic [31:0] x, int k);
			return (x << k) | (x >> (32 - k));
		endfunction

		function void refill();
			int ra, rb, rc;
			logic [31:0] e;
			logic [6:0] slot;
			case (rot_sel)
				2'd0: begin ra = 14; rb = 9; rc = 16; end
				2'd1: begin ra = 17; rb = 8; rc = 14; end
				2'd2: begin ra = 17; rb = 19; rc = 30; end
				default: begin ra = 15; rb = 9; rc = 24; end
			endcase
			for (int i = 0; i < POOL_DEPTH; i++) begin
				slot = md[6:0];
				e = pool_words[slot] - rol(mb, ra);
				pool_words[slot] = mb ^ rol(mc, rb);
				mb = mc + rol(md, rc);
				mc = md + e;
				md = e + pool_words[mb[6:0]];
				out_words[i] = md;
			end
			rot_sel = mc[1:0];
			refills++;
		endfunction

		function logic [31:0] next_word();
			logic [31:0] r;
			r = out_words[draw_ptr];
			if (draw_ptr == 7'd127)
				refill();
			draw_ptr = draw_ptr + 7'd1;
			return r;
		endfunction

		function void note_request(req_t req, logic [6:0] bidx, logic [7:0] kb);
			logic [4:0] sh;
			case (req)
				REQ_RESTART: restart();
				REQ_KEY: begin
					sh = {bidx[1:0], 3'd0};
					pool_words[bidx[6:2]] = (pool_words[bidx[6:2]] & ~(32'hff << sh))
						| ({24'd0, kb} << sh);
				end
				REQ_COMMIT: begin
					refill();
					for (int n = 0; n < warmup; n++)
						void'(next_word());
				end
				default: expected_words.push_back(next_word());
			endcase
		endfunction

		function void check_word(logic [31:0] got);
			logic [31:0] want;
			draws_seen++;
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = expected_words.pop_front();
			if (got !== want) begin
				$display("%0t: random_value mismatch, expected %h, actual %h", $time, want, got);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  req_type;
	logic [6:0]  key_byte_index;
	logic [7:0]  key_byte;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] random_value;

	keystream_scoreboard sb = new();
	int send_idle;
	int recv_idle;
	int hold_request;
	int hold_left;
	int stall_count;
	int items_sent;

	shuffle_pool_keystream_generator dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.key_byte_index(key_byte_index),
		.key_byte(key_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.random_value(random_value)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// receiver: random stalls, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_request = 0;
			hold_left = 600;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else
			out_ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid && out_ready)
			sb.check_word(random_value);
	end

	// watchdog: count cycles without progress while work is outstanding
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_count <= 0;
			else if (in_valid || sb.expected_words.size() != 0)
				stall_count <= stall_count + 1;
			if (stall_count > 1000000) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	task automatic send(req_t req, logic [6:0] bidx, logic [7:0] kb);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		key_byte_index <= bidx;
		key_byte <= kb;
		do @(posedge clk); while (!in_ready);
		sb.note_request(req, bidx, kb);
		items_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.expected_words.size() != 0)
			@(posedge clk);
	endtask

	// wait out any commit still running, then write the register
	task automatic write_warmup(logic [15:0] v);
		drain();
		// a draw result means every earlier beat has been carried out
		send(REQ_DRAW, 7'd0, 8'd0);
		drain();
		// let a refill behind that draw finish
		repeat (400) @(posedge clk);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.warmup = v;
	endtask

	task automatic send_random();
		int r;
		r = $urandom_range(99);
		if (r < 3)
			send(REQ_RESTART, 7'($urandom), 8'($urandom));
		else if (r < 18)
			send(REQ_KEY, 7'($urandom_range(127)), 8'($urandom_range(255)));
		else if (r < 21)
			send(REQ_COMMIT, 7'($urandom), 8'($urandom));
		else
			send(REQ_DRAW, 7'($urandom), 8'($urandom));
	endtask

	task automatic random_phase(int n, int s_idle, int r_idle, logic [15:0] wu);
		write_warmup(wu);
		send_idle = s_idle;
		recv_idle = r_idle;
		for (int i = 0; i < n; i++) begin
			if (i == 100)
				hold_request = 1;
			if (i == 250)
				drain();
			send_random();
		end
	endtask

	initial begin
		sb.restart();
		sb.warmup = 16'd0;
		sb.errors = 0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 16'd0;
		in_valid = 1'b0;
		req_type = REQ_DRAW;
		key_byte_index = 7'd0;
		key_byte = 8'd0;
		out_ready = 1'b0;
		send_idle = 0;
		recv_idle = 0;
		hold_request = 0;
		hold_left = 0;
		stall_count = 0;
		items_sent = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: draws from the zero buffer, key byte extremes, commits, restarts
		write_warmup(16'd0);
		send(REQ_DRAW, 7'h7f, 8'hff);
		send(REQ_KEY, 7'd0, 8'hff);
		send(REQ_KEY, 7'd127, 8'h00);
		send(REQ_KEY, 7'd1, 8'h5a);
		send(REQ_KEY, 7'd126, 8'ha5);
		send(REQ_COMMIT, 7'h7f, 8'hff);
		send(REQ_DRAW, 7'd0, 8'd0);
		send(REQ_DRAW, 7'd0, 8'd0);
		send(REQ_KEY, 7'd64, 8'h81);
		send(REQ_DRAW, 7'd0, 8'd0);
		send(REQ_COMMIT, 7'd0, 8'd0);
		send(REQ_DRAW, 7'd0, 8'd0);
		send(REQ_RESTART, 7'h55, 8'haa);
		send(REQ_DRAW, 7'd0, 8'd0);
		send(REQ_COMMIT, 7'd0, 8'd0);
		send(REQ_DRAW, 7'd0, 8'd0);
		write_warmup(16'hffff);
		send(REQ_COMMIT, 7'd0, 8'd0);
		send(REQ_DRAW, 7'd0, 8'd0);
		send(REQ_DRAW, 7'd0, 8'd0);

		random_phase(400, 17, 46, 16'd37);
		random_phase(400, 46, 17, 16'd200);
		random_phase(400, 0, 0, 16'd1);

		drain();
		repeat (2000) @(posedge clk);
		$display("covered %0d requests, %0d draws checked, %0d refills predicted",
			items_sent, sb.draws_seen, sb.refills);
		$display("warm-up settings 0, 1, 37, 200, 65535 with both idle mixes and a long stall");
		if (sb.errors == 0 && sb.expected_words.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
`default_nettype wire

// File: sim.f
design/spkg_pkg.sv
design/spkg_ram.sv
design/spkg_front.sv
design/spkg_engine.sv
design/shuffle_pool_keystream_generator.sv
bench/tb_shuffle_pool_keystream_generator.sv
